FILE: rtl/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, constants and class geometry for the size-class allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int NUM_CLASSES        = 4;
  localparam int BLOCKS_FIRST_CLASS = 16;
  localparam int MIN_BLOCK_BYTES    = 64;

  localparam int MODE_W  = 2;
  localparam int BYTES_W = 16;
  localparam int HANDLE_W = 5;
  localparam int DATA_W  = 24;

  // Blocks held by class c.
  function automatic int class_blocks(int c);
    int n;
    n = BLOCKS_FIRST_CLASS >> c;
    if (n < 2) n = 2;
    return n;
  endfunction

  // First handle owned by class c.
  function automatic int class_base(int c);
    int b;
    b = 0;
    for (int k = 0; k < c; k++) b += class_blocks(k);
    return b;
  endfunction

  // Capacity of class c, kept to the result field width.
  function automatic logic [BYTES_W-1:0] class_capacity(int c);
    int cap;
    cap = MIN_BLOCK_BYTES * (c + 1);
    return cap[BYTES_W-1:0];
  endfunction

  localparam int TOTAL_BLOCKS = class_base(NUM_CLASSES);
  localparam int SLOT_W       = $clog2(TOTAL_BLOCKS);
  localparam int FILL_W       = $clog2(BLOCKS_FIRST_CLASS + 1);

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [FILL_W-1:0]   fill_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_SET   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_NULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    mode_e                mode;
    logic [BYTES_W-1:0]   request_bytes;
    handle_t              block_handle;
    logic                 handle_given;
  } req_t;

  typedef struct packed {
    status_e              status;
    handle_t              granted_handle;
    logic [BYTES_W-1:0]   capacity_bytes;
    logic                 valid_mark;
  } res_t;

endpackage

FILE: rtl/scba_core.sv
// ----------------------------------------------------------------------------
// scba_core
// Free stacks, fill counts and valid marks; works out one request's result
// and commits its state change when the request advances.
// ----------------------------------------------------------------------------
module scba_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scba_pkg::req_t    req_i,
  input  logic              commit_i,
  output scba_pkg::res_t    res_o
);

  scba_pkg::handle_t store_q [scba_pkg::TOTAL_BLOCKS];
  scba_pkg::handle_t store_d [scba_pkg::TOTAL_BLOCKS];
  scba_pkg::fill_t   fill_q  [scba_pkg::NUM_CLASSES];
  scba_pkg::fill_t   fill_d  [scba_pkg::NUM_CLASSES];
  logic [scba_pkg::TOTAL_BLOCKS-1:0] mark_q, mark_d;

  logic                found, hit, full;
  scba_pkg::slot_t     pop_slot, push_slot, hslot;
  logic [scba_pkg::BYTES_W-1:0] pop_cap;
  scba_pkg::handle_t   popped;
  logic [scba_pkg::NUM_CLASSES-1:0] pick, hsel;

  always_comb begin
    found     = 1'b0;
    pick      = '0;
    pop_slot  = '0;
    pop_cap   = '0;
    hit       = 1'b0;
    hsel      = '0;
    push_slot = '0;
    full      = 1'b0;
    // Lowest class that is large enough and still has a free block.
    for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
      if (!found && fill_q[c] != '0 &&
          32'(req_i.request_bytes) <= 32'(scba_pkg::MIN_BLOCK_BYTES * (c + 1))) begin
        found    = 1'b1;
        pick[c]  = 1'b1;
        pop_slot = scba_pkg::SLOT_W'(scba_pkg::class_base(c)) +
                   scba_pkg::SLOT_W'(fill_q[c]) - scba_pkg::SLOT_W'(1);
        pop_cap  = scba_pkg::class_capacity(c);
      end
    end
    // Class that owns the named handle.
    for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
      if (32'(req_i.block_handle) >= 32'(scba_pkg::class_base(c)) &&
          32'(req_i.block_handle) <
            32'(scba_pkg::class_base(c) + scba_pkg::class_blocks(c))) begin
        hit       = req_i.handle_given;
        hsel[c]   = 1'b1;
        push_slot = scba_pkg::SLOT_W'(scba_pkg::class_base(c)) +
                    scba_pkg::SLOT_W'(fill_q[c]);
        full      = fill_q[c] == scba_pkg::FILL_W'(scba_pkg::class_blocks(c));
      end
    end
  end

  assign popped = store_q[pop_slot];
  assign hslot  = scba_pkg::SLOT_W'(req_i.block_handle);

  always_comb begin
    store_d = store_q;
    fill_d  = fill_q;
    mark_d  = mark_q;
    res_o   = '0;
    res_o.status = scba_pkg::ST_OK;
    unique case (req_i.mode)
      scba_pkg::MODE_ALLOC: begin
        if (found) begin
          res_o.granted_handle = popped;
          res_o.capacity_bytes = pop_cap;
          mark_d[scba_pkg::SLOT_W'(popped)] = 1'b0;
          for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
            if (pick[c]) fill_d[c] = fill_q[c] - scba_pkg::FILL_W'(1);
          end
        end else begin
          res_o.status = scba_pkg::ST_NONE;
        end
      end
      scba_pkg::MODE_FREE: begin
        if (!hit) begin
          res_o.status = scba_pkg::ST_NULL;
        end else if (full) begin
          res_o.status = scba_pkg::ST_OVERFLOW;
        end else begin
          store_d[push_slot] = req_i.block_handle;
          mark_d[hslot]      = 1'b0;
          for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
            if (hsel[c]) fill_d[c] = fill_q[c] + scba_pkg::FILL_W'(1);
          end
        end
      end
      scba_pkg::MODE_SET: begin
        if (!hit) res_o.status = scba_pkg::ST_NULL;
        else      mark_d[hslot] = 1'b1;
      end
      scba_pkg::MODE_QUERY: begin
        if (!hit) res_o.status = scba_pkg::ST_NULL;
        else      res_o.valid_mark = mark_q[hslot];
      end
      default: res_o.status = scba_pkg::ST_NULL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < scba_pkg::TOTAL_BLOCKS; i++) begin
        store_q[i] <= scba_pkg::HANDLE_W'(i);
      end
      for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
        fill_q[c] <= scba_pkg::FILL_W'(scba_pkg::class_blocks(c));
      end
      mark_q <= '0;
    end else if (commit_i) begin
      store_q <= store_d;
      fill_q  <= fill_d;
      mark_q  <= mark_d;
    end
  end

endmodule

FILE: rtl/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Segregated free-list allocator over a small block pool held in flip-flops.
// ----------------------------------------------------------------------------
// One request enters per cycle while results drain. A request register feeds
// the stack lookup and class pick, whose result is loaded into the output
// register when the request advances. State changes commit as the request
// moves into the output register, so back-to-back requests see each other.
// A stalled result holds the output register, then the request register, and
// only then drops s_axis_tready_o.
// All state is ready straight out of reset; no initialisation sweep runs.
module size_class_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] mode, [17:2] request_bytes, [22:18] block_handle, [23] handle_given
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [6:2] granted_handle, [22:7] capacity_bytes, [23] valid_mark
  output logic [23:0] m_axis_tdata_o
);

  logic            req_valid_q, out_valid_q;
  scba_pkg::req_t  req_q, req_d;
  scba_pkg::res_t  res, out_q;
  logic            advance;

  assign advance         = req_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !req_valid_q || advance;

  always_comb begin
    req_d.mode          = scba_pkg::mode_e'(s_axis_tdata_i[1:0]);
    req_d.request_bytes = s_axis_tdata_i[17:2];
    req_d.block_handle  = s_axis_tdata_i[22:18];
    req_d.handle_given  = s_axis_tdata_i[23];
  end

  scba_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_q),
    .commit_i(advance),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) req_valid_q <= s_axis_tvalid_i;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) req_q <= req_d;
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.valid_mark, out_q.capacity_bytes,
                            out_q.granted_handle, out_q.status};

endmodule

FILE: rtl/scba_checker.sv
// ----------------------------------------------------------------------------
// scba_checker
// Port-level checks on the allocator's result stream.
// ----------------------------------------------------------------------------
module scba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  logic [1:0]  status;
  logic [4:0]  granted;
  logic [15:0] cap;
  logic        vmark;

  assign status  = m_axis_tdata_o[1:0];
  assign granted = m_axis_tdata_o[6:2];
  assign cap     = m_axis_tdata_o[22:7];
  assign vmark   = m_axis_tdata_o[23];

  // Hold a stalled result.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A failed request carries no grant, capacity or mark.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status != scba_pkg::ST_OK |->
      granted == '0 && cap == '0 && !vmark)
    else $error("failure result carries payload");

  // A grant always comes with its class capacity.
  a_grant_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && granted != '0 |-> cap != '0)
    else $error("grant without capacity");

  // A set mark only shows on a query, which grants nothing.
  a_mark_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && vmark |-> status == scba_pkg::ST_OK && cap == '0)
    else $error("valid mark on a non-query result");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the size-class block allocator. A short table of
// requests covers the corner cases, with the expected result written out in
// the table where it is obvious. A stream of random alloc, free, set-valid and
// query requests follows and is checked against a cycle-free model of the
// class stacks. Both sides of the stream idle at random, and the result side
// also holds off for one long stretch.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 360;
  localparam int PRESSURE_CYCLES  = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int NUM_ROWS         = 25;

  typedef struct {
    scba_pkg::req_t rq;
    bit             typed;
    scba_pkg::res_t want;
  } table_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  // Model of the pool: stack contents, fill levels and per-block valid marks
  scba_pkg::handle_t free_slots [32];
  int      fill_level [scba_pkg::NUM_CLASSES];
  int      class_first [scba_pkg::NUM_CLASSES];
  int      class_size [scba_pkg::NUM_CLASSES];
  bit      marks [32];
  bit      held [32];

  scba_pkg::res_t expected_results [$];
  int      fault_count     = 0;
  int      issued_count    = 0;
  int      grant_count     = 0;
  int      refused_count   = 0;
  int      null_count      = 0;
  int      double_free_count = 0;
  int      load_phase      = 0;
  int      sender_idle_pct = 0;
  int      recv_idle_pct   = 0;

  // Directed requests, all issued straight after reset
  table_row_t opening_rows [NUM_ROWS] = '{
    '{'{scba_pkg::MODE_QUERY, 16'd0, 5'd0, 1'b1}, 1'b1,
      '{scba_pkg::ST_OK, 5'd0, 16'd0, 1'b0}},
    '{'{scba_pkg::MODE_ALLOC, 16'd0, 5'd0, 1'b0}, 1'b1,
      '{scba_pkg::ST_OK, 5'd15, 16'd64, 1'b0}},
    '{'{scba_pkg::MODE_ALLOC, 16'hFFFF, 5'd31, 1'b1}, 1'b1,
      '{scba_pkg::ST_NONE, 5'd0, 16'd0, 1'b0}},
    '{'{scba_pkg::MODE_ALLOC, 16'd257, 5'd0, 1'b0}, 1'b1,
      '{scba_pkg::ST_NONE, 5'd0, 16'd0, 1'b0}},
    '{'{scba_pkg::MODE_ALLOC, 16'd256, 5'd0, 1'b0}, 1'b1,
      '{scba_pkg::ST_OK, 5'd29, 16'd256, 1'b0}},
    '{'{scba_pkg::MODE_ALLOC, 16'd1, 5'd0, 1'b0}, 1'b1,
      '{scba_pkg::ST_OK, 5'd14, 16'd64, 1'b0}},
    '{'{scba_pkg::MODE_FREE, 16'd0, 5'd14, 1'b0}, 1'b1,
      '{scba_pkg::ST_NULL, 5'd0, 16'd0, 1'b0}},
    '{'{scba_pkg::MODE_FREE, 16'd0, 5'd31, 1'b1}, 1'b1,
      '{scba_pkg::ST_NULL, 5'd0, 16'd0, 1'b0}},
    '{'{scba_pkg::MODE_SET, 16'd0, 5'd30, 1'b1}, 1'b1,
      '{scba_pkg::ST_NULL, 5'd0, 16'd0, 1'b0}},
    '{'{scba_pkg::MODE_QUERY, 16'd0, 5'd31, 1'b1}, 1'b1,
      '{scba_pkg::ST_NULL, 5'd0, 16'd0, 1'b0}},
    '{'{scba_pkg::MODE_FREE,  16'd0,    5'd0,  1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_FREE,  16'd0,    5'd1,  1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_FREE,  16'd0,    5'd2,  1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_SET,   16'd0,    5'd5,  1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_QUERY, 16'd0,    5'd5,  1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_ALLOC, 16'd64,   5'd5,  1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_FREE,  16'd0,    5'd29, 1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_SET,   16'd0,    5'd29, 1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_ALLOC, 16'd193,  5'd0,  1'b0}, 1'b0, '0},
    '{'{scba_pkg::MODE_QUERY, 16'd0,    5'd29, 1'b1}, 1'b0, '0},
    '{'{scba_pkg::MODE_ALLOC, 16'd193,  5'd0,  1'b0}, 1'b0, '0},
    '{'{scba_pkg::MODE_ALLOC, 16'd200,  5'd0,  1'b0}, 1'b0, '0},
    '{'{scba_pkg::MODE_ALLOC, 16'd129,  5'd0,  1'b0}, 1'b0, '0},
    '{'{scba_pkg::MODE_QUERY, 16'hFFFF, 5'd5,  1'b0}, 1'b0, '0},
    '{'{scba_pkg::MODE_SET,   16'hFFFF, 5'd0,  1'b1}, 1'b0, '0}
  };

  size_class_block_allocator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the result of one request and update the pool model
  function automatic scba_pkg::res_t apply_request(scba_pkg::req_t rq);
    scba_pkg::res_t rs;
    int   cls;
    int   c;
    int   owner;
    int   slot;
    rs = '0;
    if (rq.mode == scba_pkg::MODE_ALLOC) begin
      cls = (rq.request_bytes == 0) ? 0 :
            (int'(rq.request_bytes) - 1) / scba_pkg::MIN_BLOCK_BYTES;
      c = cls;
      // fall through to larger classes while the wanted one is empty
      while (c < scba_pkg::NUM_CLASSES && fill_level[c] == 0) c++;
      if (c >= scba_pkg::NUM_CLASSES) begin
        rs.status = scba_pkg::ST_NONE;
      end else begin
        slot = class_first[c] + fill_level[c] - 1;
        fill_level[c]--;
        rs.granted_handle = free_slots[slot];
        rs.capacity_bytes = 16'(scba_pkg::MIN_BLOCK_BYTES * (c + 1));
        marks[rs.granted_handle] = 1'b0;
        held[rs.granted_handle] = 1'b1;
      end
    end else begin
      owner = -1;
      if (rq.handle_given) begin
        for (int k = 0; k < scba_pkg::NUM_CLASSES; k++) begin
          if (int'(rq.block_handle) >= class_first[k] &&
              int'(rq.block_handle) < class_first[k] + class_size[k]) owner = k;
        end
      end
      if (owner < 0) begin
        rs.status = scba_pkg::ST_NULL;
      end else if (rq.mode == scba_pkg::MODE_FREE) begin
        if (fill_level[owner] >= class_size[owner]) begin
          rs.status = scba_pkg::ST_OVERFLOW;
        end else begin
          free_slots[class_first[owner] + fill_level[owner]] = rq.block_handle;
          fill_level[owner]++;
          marks[rq.block_handle] = 1'b0;
          held[rq.block_handle] = 1'b0;
        end
      end else if (rq.mode == scba_pkg::MODE_SET) begin
        marks[rq.block_handle] = 1'b1;
      end else begin
        rs.valid_mark = marks[rq.block_handle];
      end
    end
    return rs;
  endfunction

  // Offer one request, idling first at the current rate, and log its result
  task automatic offer(input scba_pkg::req_t rq, input bit typed,
                       input scba_pkg::res_t want);
    scba_pkg::res_t predicted;
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {rq.handle_given, rq.block_handle, rq.request_bytes, rq.mode};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_request(rq);
    expected_results.push_back(typed ? want : predicted);
    issued_count++;
  endtask

  initial begin : request_side
    int      base;
    int      roll;
    scba_pkg::req_t    rq;
    scba_pkg::handle_t pool [$];
    base = 0;
    for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
      class_size[c] = (scba_pkg::BLOCKS_FIRST_CLASS >> c) < 2 ? 2 :
                      (scba_pkg::BLOCKS_FIRST_CLASS >> c);
      class_first[c] = base;
      fill_level[c] = class_size[c];
      for (int j = 0; j < class_size[c]; j++) begin
        free_slots[base + j] = scba_pkg::handle_t'(base + j);
      end
      base += class_size[c];
    end
    foreach (marks[h]) begin
      marks[h] = 1'b0;
      held[h] = 1'b0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      load_phase = phase;
      sender_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 68 : 0;
      recv_idle_pct   = (phase == 0) ? 68 : (phase == 1) ? 35 : 0;
      if (phase == 0) begin
        foreach (opening_rows[i]) offer(opening_rows[i].rq, opening_rows[i].typed,
                                        opening_rows[i].want);
      end
      repeat (RANDOM_PER_PHASE) begin
        roll = $urandom_range(99);
        rq.request_bytes = 16'($urandom);
        rq.block_handle  = 5'($urandom);
        rq.handle_given  = ($urandom_range(19) != 0);
        if (roll < 35) begin
          rq.mode = scba_pkg::MODE_ALLOC;
          // keep most sizes at or below 300 bytes
          if ($urandom_range(9) != 0) rq.request_bytes = 16'($urandom_range(300));
        end else if (roll < 65) begin
          rq.mode = scba_pkg::MODE_FREE;
          pool.delete();
          foreach (held[h]) if (held[h]) pool.push_back(scba_pkg::handle_t'(h));
          if (pool.size() > 0 && $urandom_range(3) != 0) begin
            rq.block_handle = pool[$urandom_range(pool.size() - 1)];
            rq.handle_given = 1'b1;
          end
        end else if (roll < 80) begin
          rq.mode = scba_pkg::MODE_SET;
        end else begin
          rq.mode = scba_pkg::MODE_QUERY;
        end
        offer(rq, 1'b0, '0);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d requests over three idle patterns and one long output stall.",
             issued_count);
    $display("Grants %0d, refused allocations %0d, null or absent handles %0d, double frees %0d.",
             grant_count, refused_count, null_count, double_free_count);
    if (fault_count == 0) begin
      $display("PASS size_class_block_allocator");
    end else begin
      $display("FAIL size_class_block_allocator");
    end
    $finish;
  end

  initial begin : result_side
    int   stall_left;
    bit   pressure_done;
    scba_pkg::res_t got;
    scba_pkg::res_t want;
    stall_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status         = scba_pkg::status_e'(m_axis_tdata_o[1:0]);
        got.granted_handle = m_axis_tdata_o[6:2];
        got.capacity_bytes = m_axis_tdata_o[22:7];
        got.valid_mark     = m_axis_tdata_o[23];
        if (expected_results.size() == 0) begin
          $error("unexpected result 0x%06h with no request pending", m_axis_tdata_o);
          fault_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fault_count++;
          end
          if (got.granted_handle !== want.granted_handle) begin
            $error("granted_handle: expected %0d, got %0d",
                   want.granted_handle, got.granted_handle);
            fault_count++;
          end
          if (got.capacity_bytes !== want.capacity_bytes) begin
            $error("capacity_bytes: expected %0d, got %0d",
                   want.capacity_bytes, got.capacity_bytes);
            fault_count++;
          end
          if (got.valid_mark !== want.valid_mark) begin
            $error("valid_mark: expected %0d, got %0d", want.valid_mark, got.valid_mark);
            fault_count++;
          end
          case (want.status)
            scba_pkg::ST_OK:       if (want.capacity_bytes != 0) grant_count++;
            scba_pkg::ST_NONE:     refused_count++;
            scba_pkg::ST_NULL:     null_count++;
            scba_pkg::ST_OVERFLOW: double_free_count++;
            default: ;
          endcase
        end
      end
      // hold off once for long enough to back the pipeline up to the input
      if (load_phase == 2 && !pressure_done) begin
        stall_left = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Timed out after %0d cycles with no request or result moving.", quiet);
        $display("FAIL size_class_block_allocator");
        $finish;
      end
    end
  end

endmodule

FILE: size_class_block_allocator.f
rtl/scba_pkg.sv
rtl/scba_core.sv
rtl/size_class_block_allocator.sv
rtl/scba_checker.sv
test/testbench.sv
